/* design/pidv_pkg.sv */
// Package for the variable time step PID controller.
// Holds widths, register indexes, reset values, the gain struct and the sequencer states.
// No dependencies.
package pidv_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int TIME_FRAC_BITS = 16;

    localparam int DATA_W  = 16;
    localparam int ERR_W   = DATA_W + 1;
    localparam int DERR_W  = ERR_W + 1;
    localparam int INTEG_W = 48;
    // |error change| < 2^ERR_W, so the dividend magnitude fits here
    localparam int NUM_W   = ERR_W + TIME_FRAC_BITS;
    localparam int DERIV_W = NUM_W + 1;
    localparam int ACC_W   = 64;

    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SPLIT   = 24;

    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;

    localparam logic signed [DATA_W-1:0] GAIN_P_RESET = 16'sd205;
    localparam logic signed [DATA_W-1:0] GAIN_I_RESET = 16'sd0;
    localparam logic signed [DATA_W-1:0] GAIN_D_RESET = 16'sd0;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    localparam logic [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [ACC_W-1:0] DRIVE_MAX = 64'sd32767;
    localparam logic signed [ACC_W-1:0] DRIVE_MIN = -64'sd32768;

    typedef logic signed [DATA_W-1:0] gain_t;

    typedef struct packed {
        gain_t kp;
        gain_t ki;
        gain_t kd;
    } gains_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR_DT,
        ST_KP_ERR,
        ST_KI_LO,
        ST_KI_HI,
        ST_ITERM,
        ST_ITERM_ACC,
        ST_WAIT_DIV,
        ST_KD_LO,
        ST_KD_HI,
        ST_KD_ACC,
        ST_FINISH
    } state_t;

endpackage

/* design/pidv_if.sv */
// Stream interfaces for the PID controller: sample channel in, result channel out.
// Depends on pidv_pkg.
interface pidv_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [pidv_pkg::DATA_W-1:0]  target;
    logic signed [pidv_pkg::DATA_W-1:0]  measured;
    logic        [pidv_pkg::DATA_W-1:0]  time_step;

    modport source (output valid, target, measured, time_step, input ready);
    modport sink   (input valid, target, measured, time_step, output ready);
endinterface

interface pidv_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pidv_pkg::DATA_W-1:0]  drive;
    logic                                clipped;

    modport source (output valid, drive, clipped, input ready);
    modport sink   (input valid, drive, clipped, output ready);
endinterface

/* design/pidv_cfg.sv */
// APB-style register file holding the three Q8.8 gains.
// Depends on pidv_pkg.
module pidv_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pidv_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [pidv_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [pidv_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output pidv_pkg::gains_t                     gains
);

    pidv_pkg::gains_t gains_reg;
    pidv_pkg::gains_t gains_next;
    logic [1:0]       idx;
    logic             wr_en;

    assign idx    = paddr[pidv_pkg::CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign gains  = gains_reg;

    always_comb
    begin
        gains_next = gains_reg;
        if (wr_en)
        begin
            case (idx)
                pidv_pkg::REG_GAIN_P: gains_next.kp = pwdata[pidv_pkg::DATA_W-1:0];
                pidv_pkg::REG_GAIN_I: gains_next.ki = pwdata[pidv_pkg::DATA_W-1:0];
                pidv_pkg::REG_GAIN_D: gains_next.kd = pwdata[pidv_pkg::DATA_W-1:0];
                default:              gains_next = gains_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            pidv_pkg::REG_GAIN_P: prdata = pidv_pkg::CFG_DATA_W'(unsigned'(gains_reg.kp));
            pidv_pkg::REG_GAIN_I: prdata = pidv_pkg::CFG_DATA_W'(unsigned'(gains_reg.ki));
            pidv_pkg::REG_GAIN_D: prdata = pidv_pkg::CFG_DATA_W'(unsigned'(gains_reg.kd));
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.kp <= pidv_pkg::GAIN_P_RESET;
            gains_reg.ki <= pidv_pkg::GAIN_I_RESET;
            gains_reg.kd <= pidv_pkg::GAIN_D_RESET;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

endmodule

/* design/pidv_mult.sv */
// Shared signed multiplier, 18 x 26 bits, product registered.
// Depends on pidv_pkg.
module pidv_mult (
    input  logic                                 clk,
    input  logic signed [pidv_pkg::MUL_A_W-1:0]  a,
    input  logic signed [pidv_pkg::MUL_B_W-1:0]  b,
    output logic signed [pidv_pkg::MUL_P_W-1:0]  p
);

    logic signed [pidv_pkg::MUL_P_W-1:0] p_reg;
    logic signed [pidv_pkg::MUL_P_W-1:0] p_next;

    assign p_next = pidv_pkg::MUL_P_W'(a) * pidv_pkg::MUL_P_W'(b);
    assign p      = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

/* design/pidv_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pidv_pkg.
module pidv_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pidv_pkg::NUM_W-1:0]          numer,
    input  logic [pidv_pkg::DATA_W-1:0]         denom,
    output logic                                busy,
    output logic [pidv_pkg::NUM_W-1:0]          quot
);

    localparam int NW = pidv_pkg::NUM_W;
    localparam int DW = pidv_pkg::DATA_W;
    localparam int CW = pidv_pkg::DIV_CNT_W;

    logic [DW-1:0] rem_reg,   rem_next;
    logic [NW-1:0] quo_reg,   quo_next;
    logic [DW-1:0] den_reg,   den_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic          busy_reg,  busy_next;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = !diff[DW+1];
    assign busy    = busy_reg;
    assign quot    = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = numer;
            den_next  = denom;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

/* design/pid_controller_variable_dt_unit.sv */
// Top level of the variable time step PID controller: sequencer and datapath.
// Depends on pidv_pkg, pidv_if, pidv_cfg, pidv_mult and pidv_div.
//
// Usage:
//   sample channel: target, measured (signed) and time_step (unsigned, 2^-16 s units).
//   result channel: drive (saturated signed 16 bits) and clipped.
//   Gains gain_p, gain_i, gain_d (signed Q8.8) sit at APB byte addresses 0, 4, 8;
//   write them only while no sample is in flight.
// Timing:
//   One sample at a time. A transfer on the sample channel starts a 33-step divide
//   for the derivative; the shared multiplier forms the other products meanwhile.
//   The next sample is taken only once the result of the last one has been loaded
//   into the output register.
// Reset clears the integral, the last error and result.valid, and loads the reset
// gains. The result sits in an output register; a new sample is taken while it
// waits, but that sample's result is held back until the receiver takes the old one.
module pid_controller_variable_dt_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    pidv_sample_if.sink                         sample,
    pidv_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pidv_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pidv_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pidv_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int DW  = pidv_pkg::DATA_W;
    localparam int EW  = pidv_pkg::ERR_W;
    localparam int IW  = pidv_pkg::INTEG_W;
    localparam int NW  = pidv_pkg::NUM_W;
    localparam int RW  = pidv_pkg::DERIV_W;
    localparam int AW  = pidv_pkg::ACC_W;
    localparam int MAW = pidv_pkg::MUL_A_W;
    localparam int MBW = pidv_pkg::MUL_B_W;
    localparam int MPW = pidv_pkg::MUL_P_W;
    localparam int SP  = pidv_pkg::SPLIT;

    pidv_pkg::gains_t gains;
    pidv_pkg::state_t state_reg, state_next;

    logic signed [EW-1:0] err_reg,      err_next;
    logic        [DW-1:0] dt_reg,       dt_next;
    logic signed [EW-1:0] prev_err_reg, prev_err_next;
    logic signed [IW-1:0] integ_reg,    integ_next;
    logic signed [AW-1:0] acc_reg,      acc_next;
    logic signed [AW-1:0] iprod_reg,    iprod_next;
    logic signed [RW-1:0] deriv_reg,    deriv_next;
    logic                 neg_reg,      neg_next;
    logic                 clip_reg,     clip_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DW-1:0] drive_reg,    drive_next;
    logic                 clipped_reg,  clipped_next;

    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [MPW-1:0] mul_p;
    logic                  div_start;
    logic                  div_busy;
    logic [NW-1:0]         div_quot;
    logic [NW-1:0]         div_numer;

    logic                  in_ready;
    logic                  in_xfer;
    logic                  out_load;
    logic                  out_free;

    logic signed [pidv_pkg::DERR_W-1:0] derr;
    logic        [pidv_pkg::DERR_W-1:0] derr_mag;
    logic signed [IW:0]                 integ_sum;
    logic        [RW-1:0]               quot_ext;
    logic signed [AW-1:0]               acc_rnd;
    logic signed [AW-1:0]               acc_q;

    pidv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    pidv_mult u_mult (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    pidv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (dt_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign sample.ready   = in_ready;
    assign in_xfer        = sample.valid && in_ready;
    assign result.valid   = out_valid_reg;
    assign result.drive   = drive_reg;
    assign result.clipped = clipped_reg;
    assign out_free       = !out_valid_reg || result.ready;

    assign derr      = pidv_pkg::DERR_W'(err_reg) - pidv_pkg::DERR_W'(prev_err_reg);
    assign derr_mag  = derr[pidv_pkg::DERR_W-1] ? -derr : derr;
    assign div_numer = {derr_mag[EW-1:0], {pidv_pkg::TIME_FRAC_BITS{1'b0}}};
    assign integ_sum = (IW+1)'(integ_reg) + (IW+1)'(mul_p);
    assign quot_ext  = {1'b0, div_quot};
    assign acc_rnd   = acc_reg[AW-1] ? acc_reg + pidv_pkg::TRUNC_BIAS : acc_reg;
    assign acc_q     = acc_rnd >>> pidv_pkg::GAIN_FRAC_BITS;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pidv_pkg::ST_IDLE:      if (sample.valid) state_next = pidv_pkg::ST_ERR_DT;
            pidv_pkg::ST_ERR_DT:    state_next = pidv_pkg::ST_KP_ERR;
            pidv_pkg::ST_KP_ERR:    state_next = pidv_pkg::ST_KI_LO;
            pidv_pkg::ST_KI_LO:     state_next = pidv_pkg::ST_KI_HI;
            pidv_pkg::ST_KI_HI:     state_next = pidv_pkg::ST_ITERM;
            pidv_pkg::ST_ITERM:     state_next = pidv_pkg::ST_ITERM_ACC;
            pidv_pkg::ST_ITERM_ACC: state_next = pidv_pkg::ST_WAIT_DIV;
            pidv_pkg::ST_WAIT_DIV:  if (!div_busy) state_next = pidv_pkg::ST_KD_LO;
            pidv_pkg::ST_KD_LO:     state_next = pidv_pkg::ST_KD_HI;
            pidv_pkg::ST_KD_HI:     state_next = pidv_pkg::ST_KD_ACC;
            pidv_pkg::ST_KD_ACC:    state_next = pidv_pkg::ST_FINISH;
            pidv_pkg::ST_FINISH:    if (out_free) state_next = pidv_pkg::ST_IDLE;
            default:                state_next = pidv_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands, divider start, handshakes
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        in_ready  = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            pidv_pkg::ST_IDLE:
                in_ready = 1'b1;
            pidv_pkg::ST_ERR_DT:
            begin
                mul_a     = MAW'(err_reg);
                mul_b     = MBW'(dt_reg);
                div_start = 1'b1;
            end
            pidv_pkg::ST_KP_ERR:
            begin
                mul_a = MAW'(gains.kp);
                mul_b = MBW'(err_reg);
            end
            pidv_pkg::ST_KI_LO:
            begin
                mul_a = MAW'(gains.ki);
                mul_b = MBW'(integ_reg[SP-1:0]);
            end
            pidv_pkg::ST_KI_HI:
            begin
                mul_a = MAW'(gains.ki);
                mul_b = MBW'($signed(integ_reg[IW-1:SP]));
            end
            pidv_pkg::ST_KD_LO:
            begin
                mul_a = MAW'(gains.kd);
                mul_b = MBW'(deriv_reg[SP-1:0]);
            end
            pidv_pkg::ST_KD_HI:
            begin
                mul_a = MAW'(gains.kd);
                mul_b = MBW'($signed(deriv_reg[RW-1:SP]));
            end
            pidv_pkg::ST_FINISH:
                out_load = out_free;
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        err_next       = err_reg;
        dt_next        = dt_reg;
        prev_err_next  = prev_err_reg;
        integ_next     = integ_reg;
        acc_next       = acc_reg;
        iprod_next     = iprod_reg;
        deriv_next     = deriv_reg;
        neg_next       = neg_reg;
        clip_next      = clip_reg;
        drive_next     = drive_reg;
        clipped_next   = clipped_reg;
        out_valid_next = out_valid_reg && !result.ready;

        if (in_xfer)
        begin
            err_next  = EW'(sample.target) - EW'(sample.measured);
            dt_next   = sample.time_step;
            clip_next = 1'b0;
        end

        case (state_reg)
            pidv_pkg::ST_ERR_DT:
            begin
                neg_next      = derr[pidv_pkg::DERR_W-1];
                prev_err_next = err_reg;
            end
            pidv_pkg::ST_KP_ERR:
            begin
                if (integ_sum[IW] != integ_sum[IW-1])
                begin
                    integ_next = integ_sum[IW] ? pidv_pkg::INTEG_MIN : pidv_pkg::INTEG_MAX;
                    clip_next  = 1'b1;
                end
                else
                begin
                    integ_next = integ_sum[IW-1:0];
                end
            end
            pidv_pkg::ST_KI_LO:
                acc_next = AW'(mul_p);
            pidv_pkg::ST_KI_HI:
                iprod_next = AW'(mul_p);
            pidv_pkg::ST_ITERM:
                iprod_next = iprod_reg + (AW'(mul_p) <<< SP);
            pidv_pkg::ST_ITERM_ACC:
                acc_next = acc_reg + (iprod_reg >>> pidv_pkg::TIME_FRAC_BITS);
            pidv_pkg::ST_WAIT_DIV:
            begin
                // zero elapsed time: no derivative term
                if (dt_reg == '0)
                    deriv_next = '0;
                else
                    deriv_next = neg_reg ? -quot_ext : quot_ext;
            end
            pidv_pkg::ST_KD_HI:
                acc_next = acc_reg + AW'(mul_p);
            pidv_pkg::ST_KD_ACC:
                acc_next = acc_reg + (AW'(mul_p) <<< SP);
            pidv_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (acc_q > pidv_pkg::DRIVE_MAX)
                    begin
                        drive_next   = pidv_pkg::DRIVE_MAX[DW-1:0];
                        clipped_next = 1'b1;
                    end
                    else if (acc_q < pidv_pkg::DRIVE_MIN)
                    begin
                        drive_next   = pidv_pkg::DRIVE_MIN[DW-1:0];
                        clipped_next = 1'b1;
                    end
                    else
                    begin
                        drive_next   = acc_q[DW-1:0];
                        clipped_next = clip_reg;
                    end
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidv_pkg::ST_IDLE;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        dt_reg      <= dt_next;
        acc_reg     <= acc_next;
        iprod_reg   <= iprod_next;
        deriv_reg   <= deriv_next;
        neg_reg     <= neg_next;
        clip_reg    <= clip_next;
        drive_reg   <= drive_next;
        clipped_reg <= clipped_next;
    end

endmodule

/* design/pidv_checker.sv */
// Port-level checks for the PID controller, bound to the top level.
// Depends on pidv_pkg and pid_controller_variable_dt_unit.
module pidv_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [pidv_pkg::DATA_W-1:0] drive,
    input logic                               clipped
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
            pend_next = pend_reg + 2'd1;
        else if (out_xfer && !in_xfer)
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clipped))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("sample taken while previous one in flight");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a pending sample");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two samples outstanding");

endmodule

bind pid_controller_variable_dt_unit pidv_checker u_pidv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .drive     (result.drive),
    .clipped   (result.clipped)
);

/* tb/pid_controller_variable_dt_unit_test.sv */
`timescale 1ns / 100ps
// Testbench for pid_controller_variable_dt_unit: a directed table, random phases under changing
// gains and integral wind-up, results scored against known rows or an in-bench PID model.
// Depends on pidv_pkg, pidv_if and the design sources.
module pid_controller_variable_dt_unit_test;
    import pidv_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int WINDUP_ITEMS    = 24;
    localparam int SETTLE_CYCLES   = 48;
    localparam int MAX_SHOWN       = 10;
    localparam int IDLE_PCT        = 38;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 4'd12;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     clipped;
    } outcome_t;

    typedef enum logic [1:0] { ROW_SAMPLE, ROW_GAINS, ROW_UNMAPPED } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        gain_t                    kp;
        gain_t                    ki;
        gain_t                    kd;
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] measured;
        logic        [DATA_W-1:0] time_step;
        logic                     known;
        logic signed [DATA_W-1:0] drive;
        logic                     clipped;
    } row_t;

    // known rows rely on reset gains: kp = 205, ki = kd = 0
    localparam row_t DIRECTED [25] = '{
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000,
          1'b1, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'hFFFF,
          1'b1, 16'sh7FFF, 1'b1},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 16'hFFFF,
          1'b1, 16'sh8000, 1'b1},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'h0100,
          1'b1, 16'sd80, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, -16'sd100, 16'sd0, 16'h0100,
          1'b1, -16'sd80, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'h0001,
          1'b1, 16'sd0, 1'b0},
        '{ROW_UNMAPPED, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'h0000,
          1'b1, 16'sd80, 1'b0},
        '{ROW_GAINS, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'h0000,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'hFFFF,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0001,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, -16'sd7, 16'sd0, 16'hFFFF,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'h0001,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 16'h0001,
          1'b0, 16'sd0, 1'b0},
        '{ROW_GAINS, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'h0000,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'h0001,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, -16'sd3, 16'sd5, 16'hFFFF,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd20, -16'sd20, 16'h1000,
          1'b0, 16'sd0, 1'b0},
        '{ROW_GAINS, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'h0000,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'h0002,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'hFFFF,
          1'b0, 16'sd0, 1'b0},
        '{ROW_GAINS, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'h0000,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'h0003,
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 16'sd12345, -16'sd2345, 16'h0309,
          1'b0, 16'sd0, 1'b0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    pidv_sample_if smp ();
    pidv_result_if res ();

    pid_controller_variable_dt_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp),
        .result  (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gains_t                    gains_now;
    logic signed [INTEG_W-1:0] integ_acc;
    logic signed [ERR_W-1:0]   last_err;
    outcome_t                  drive_due[$];
    int                        failures;
    int                        results_seen;
    bit                        steady;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #150_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= MAX_SHOWN)
            $display("mismatch: %s", msg);
    endfunction

    // one controller update; advances the in-bench integral and last error
    function automatic outcome_t control_step(input logic signed [DATA_W-1:0] tgt,
                                              input logic signed [DATA_W-1:0] meas,
                                              input logic [DATA_W-1:0] dt);
        longint   err;
        longint   sum;
        longint   rate;
        longint   acc;
        longint   level;
        outcome_t r;
        r.clipped = 1'b0;
        err = longint'(tgt) - longint'(meas);
        sum = longint'(integ_acc) + err * longint'(dt);
        if (sum > longint'(INTEG_MAX)) begin
            sum = longint'(INTEG_MAX);
            r.clipped = 1'b1;
        end else if (sum < longint'(INTEG_MIN)) begin
            sum = longint'(INTEG_MIN);
            r.clipped = 1'b1;
        end
        integ_acc = sum[INTEG_W-1:0];
        if (dt == '0)
            rate = 0;
        else
            rate = ((err - longint'(last_err)) * (longint'(1) << TIME_FRAC_BITS))
                   / longint'(dt);
        last_err = err[ERR_W-1:0];
        acc = longint'(gains_now.kp) * err + longint'(gains_now.kd) * rate
              + ((longint'(gains_now.ki) * longint'(integ_acc)) >>> TIME_FRAC_BITS);
        level = acc / (longint'(1) << GAIN_FRAC_BITS);
        if (level > DRIVE_MAX) begin
            level = DRIVE_MAX;
            r.clipped = 1'b1;
        end else if (level < DRIVE_MIN) begin
            level = DRIVE_MIN;
            r.clipped = 1'b1;
        end
        r.drive = level[DATA_W-1:0];
        return r;
    endfunction

    task automatic write_addr(input logic [CFG_ADDR_W-1:0] addr, input gain_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[1:0] == 2'b00) begin
            case (addr[3:2])
                REG_GAIN_P: gains_now.kp = value;
                REG_GAIN_I: gains_now.ki = value;
                REG_GAIN_D: gains_now.kd = value;
                default: ;
            endcase
        end
    endtask

    task automatic set_gains(input gain_t kp, input gain_t ki, input gain_t kd);
        write_addr({REG_GAIN_P, 2'b00}, kp);
        write_addr({REG_GAIN_I, 2'b00}, ki);
        write_addr({REG_GAIN_D, 2'b00}, kd);
    endtask

    task automatic send_sample(input logic signed [DATA_W-1:0] tgt,
                               input logic signed [DATA_W-1:0] meas,
                               input logic [DATA_W-1:0] dt,
                               input logic known, input outcome_t fixed);
        outcome_t predicted;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            smp.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        smp.valid     <= 1'b1;
        smp.target    <= tgt;
        smp.measured  <= meas;
        smp.time_step <= dt;
        do @(posedge clk); while (!smp.ready);
        predicted = control_step(tgt, meas, dt);
        drive_due.push_back(known ? fixed : predicted);
    endtask

    task automatic send_random();
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] meas;
        logic        [DATA_W-1:0] dt;
        case ($urandom_range(3))
            0, 1: begin
                tgt  = DATA_W'($urandom_range(600)) - 16'sd300;
                meas = DATA_W'($urandom_range(600)) - 16'sd300;
            end
            2: begin
                tgt  = DATA_W'($urandom);
                meas = DATA_W'($urandom);
            end
            default: begin
                tgt  = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                meas = $urandom_range(1) ? DATA_W'($urandom) : -tgt;
            end
        endcase
        case ($urandom_range(9))
            0:          dt = '0;
            1:          dt = DATA_W'($urandom_range(3, 1));
            2, 3, 4, 5: dt = DATA_W'($urandom_range(4096, 1));
            default:    dt = DATA_W'($urandom);
        endcase
        send_sample(tgt, meas, dt, 1'b0, '0);
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        while (drive_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        res.ready = 1'b0;
        forever begin
            @(posedge clk);
            res.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk) begin : score
        outcome_t want;
        if (rst_n && res.valid && res.ready) begin
            results_seen++;
            if (drive_due.size() == 0) begin
                note_failure($sformatf("transfer %0d unexpected: drive %0d clipped %0b",
                                       results_seen, res.drive, res.clipped));
            end else begin
                want = drive_due.pop_front();
                if (res.drive !== want.drive || res.clipped !== want.clipped)
                    note_failure($sformatf("transfer %0d: drive exp %0d got %0d, clipped exp %0b got %0b",
                                           results_seen, want.drive, res.drive,
                                           want.clipped, res.clipped));
            end
        end
    end

    initial begin
        row_t row;
        rst_n         = 1'b0;
        smp.valid     = 1'b0;
        smp.target    = '0;
        smp.measured  = '0;
        smp.time_step = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        steady        = 1'b0;
        failures      = 0;
        results_seen  = 0;
        gains_now     = '{GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET};
        integ_acc     = '0;
        last_err      = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++) begin
            row = DIRECTED[i];
            case (row.kind)
                ROW_GAINS: begin
                    drain();
                    set_gains(row.kp, row.ki, row.kd);
                end
                ROW_UNMAPPED: begin
                    drain();
                    write_addr(ADDR_UNMAPPED, row.kp);
                end
                default: send_sample(row.target, row.measured, row.time_step, row.known,
                                     outcome_t'{row.drive, row.clipped});
            endcase
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                1: set_gains(16'sh7FFF, 16'sh8000, 16'sh7FFF);
                3: set_gains(16'sh8000, 16'sh7FFF, 16'sh8000);
                4: set_gains('0, '0, '0);
                5: set_gains(gain_t'($urandom), gain_t'($urandom), gain_t'($urandom));
                default: set_gains(gain_t'($urandom_range(1024)) - 16'sd512,
                                   gain_t'($urandom_range(8)) - 16'sd4,
                                   gain_t'($urandom_range(32)) - 16'sd16);
            endcase
            steady = (phase == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random();
                if ($urandom_range(39) == 0)
                    drain();
            end
        end

        // wind the integral up with full-scale error, then probe the integral term there
        drain();
        set_gains('0, '0, '0);
        steady = 1'b1;
        repeat (WINDUP_ITEMS) send_sample(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0, '0);
        steady = 1'b0;
        drain();
        set_gains('0, 16'sh8000, '0);
        repeat (4) send_random();
        drain();
        set_gains('0, 16'sh7FFF, '0);
        repeat (4) send_random();
        drain();
        set_gains(16'sd205, 16'sd1, 16'sd256);
        repeat (8) send_random();
        drain();

        if (failures == 0 && drive_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

/* pid_controller_variable_dt_unit.f */
design/pidv_pkg.sv
design/pidv_if.sv
design/pidv_cfg.sv
design/pidv_mult.sv
design/pidv_div.sv
design/pid_controller_variable_dt_unit.sv
design/pidv_checker.sv
tb/pid_controller_variable_dt_unit_test.sv
